// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the core RTL.
// No dependencies; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/cor_pkg.sv -----
// Shared constants and types for the circle outline rasterizer core.
// No dependencies.
package cor_pkg;

  localparam int COORD_WIDTH = 12;
  localparam int OFS_W       = COORD_WIDTH - 1;
  localparam int ERR_W       = COORD_WIDTH + 2;
  localparam int PIX_W       = COORD_WIDTH + 1;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  localparam logic [2:0] OCT_LAST = 3'd7;

  // one emitting item: offset around an origin, eight pixels
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic        [OFS_W-1:0]       ofs_x;
    logic        [OFS_W-1:0]       ofs_y;
    logic                          done;
  } job_t;

endpackage

// ----- rtl/core/cor_emit.sv -----
// Octant emitter: holds one job and sends its eight reflected pixels,
// one per cycle while out_ready allows, through a registered result stage. Depends on cor_pkg.
module cor_emit import cor_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    job_valid,
  input  job_t                    job,
  output logic                    job_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [PIX_W-1:0] out_pixel_x,
  output logic signed [PIX_W-1:0] out_pixel_y,
  output logic                    out_last_of_step,
  output logic                    out_circle_done
);

  job_t                    job_r;
  logic                    busy_r;
  logic [2:0]              cnt_r;
  logic                    out_valid_r;
  logic signed [PIX_W-1:0] px_r, py_r;
  logic                    last_r, done_r;

  logic                    out_free;
  logic                    adv;
  logic [PIX_W-1:0]        a_ext, b_ext;
  logic signed [PIX_W-1:0] ox_ext, oy_ext;
  logic signed [PIX_W-1:0] px_nxt, py_nxt;

  assign out_free  = !out_valid_r || out_ready;
  assign adv       = busy_r && out_free;
  assign job_ready = !busy_r || (out_free && (cnt_r == OCT_LAST));

  // cnt[2] swaps x/y, cnt[1] negates the column term, cnt[0] the row term
  always_comb begin
    a_ext  = {2'b00, (cnt_r[2] ? job_r.ofs_y : job_r.ofs_x)};
    b_ext  = {2'b00, (cnt_r[2] ? job_r.ofs_x : job_r.ofs_y)};
    ox_ext = PIX_W'(job_r.origin_x);
    oy_ext = PIX_W'(job_r.origin_y);
    px_nxt = cnt_r[1] ? (ox_ext - $signed(a_ext)) : (ox_ext + $signed(a_ext));
    py_nxt = cnt_r[0] ? (oy_ext - $signed(b_ext)) : (oy_ext + $signed(b_ext));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= busy_r;
      end
      if (job_valid && job_ready) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (adv) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == OCT_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      job_r <= job;
    end
    if (adv) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      last_r <= (cnt_r == OCT_LAST);
      done_r <= (cnt_r == OCT_LAST) && job_r.done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = px_r;
  assign out_pixel_y      = py_r;
  assign out_last_of_step = last_r;
  assign out_circle_done  = done_r;

endmodule

// ----- rtl/core/circle_outline_rasterizer_core.sv -----
// Circle outline rasterizer top level: midpoint circle state and step math,
// feeding the octant emitter. Depends on cor_pkg, cor_emit, assert_macros.svh.
//
//   channel | ports                                   | dir
//   in      | in_valid/in_ready, mode, center, radius | in
//   out     | out_valid/out_ready, pixel, flags       | out
//
// An emitting item yields eight pixels, one per cycle while out_ready allows;
// the next item can be taken as the eighth enters the single result register.
// A step with no circle active is accepted and emits nothing.
// in_ready drops while a job's pixels are pending; it rises again in the
// cycle the eighth pixel enters the result register.
// Synchronous active-low reset clears the circle state, the emitter's busy flag and out_valid.
`include "assert_macros.svh"

module circle_outline_rasterizer_core import cor_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic        [OFS_W-1:0]       in_radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [PIX_W-1:0]       out_pixel_x,
  output logic signed [PIX_W-1:0]       out_pixel_y,
  output logic                          out_last_of_step,
  output logic                          out_circle_done
);

  localparam int EW = ERR_W + 3;

  logic        [OFS_W-1:0]       offset_x_r, offset_x_nxt;
  logic        [OFS_W-1:0]       offset_y_r, offset_y_nxt;
  logic signed [ERR_W-1:0]       err_r, err_nxt;
  logic signed [COORD_WIDTH-1:0] origin_x_r, origin_x_nxt;
  logic signed [COORD_WIDTH-1:0] origin_y_r, origin_y_nxt;
  logic                          active_r;

  logic              accept;
  logic              emit;
  logic              done;
  logic signed [EW-1:0] e1, e2;
  logic        [EW-1:0] ae1, ae2;
  logic              keep_x;
  job_t              job;

  assign accept = in_valid && in_ready;

  always_comb begin
    e1     = EW'(err_r) + $signed({{(EW-OFS_W-1){1'b0}}, offset_y_r, 1'b1});
    e2     = e1 - $signed({{(EW-OFS_W-1){1'b0}}, offset_x_r, 1'b1});
    ae1    = e1[EW-1] ? EW'(-e1) : EW'(e1);
    ae2    = e2[EW-1] ? EW'(-e2) : EW'(e2);
    keep_x = ae1 < ae2;

    if (in_mode == MODE_START) begin
      origin_x_nxt = in_center_x;
      origin_y_nxt = in_center_y;
      offset_x_nxt = in_radius;
      offset_y_nxt = '0;
      err_nxt      = '0;
      emit         = 1'b1;
    end else begin
      origin_x_nxt = origin_x_r;
      origin_y_nxt = origin_y_r;
      offset_x_nxt = keep_x ? offset_x_r : (offset_x_r - OFS_W'(1));
      offset_y_nxt = offset_y_r + OFS_W'(1);
      err_nxt      = keep_x ? e1[ERR_W-1:0] : e2[ERR_W-1:0];
      emit         = active_r;
    end
    done = !(offset_x_nxt > offset_y_nxt);

    job.origin_x = origin_x_nxt;
    job.origin_y = origin_y_nxt;
    job.ofs_x    = offset_x_nxt;
    job.ofs_y    = offset_y_nxt;
    job.done     = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r <= '0;
      offset_y_r <= '0;
      err_r      <= '0;
      origin_x_r <= '0;
      origin_y_r <= '0;
      active_r   <= 1'b0;
    end else if (accept && emit) begin
      offset_x_r <= offset_x_nxt;
      offset_y_r <= offset_y_nxt;
      err_r      <= err_nxt;
      origin_x_r <= origin_x_nxt;
      origin_y_r <= origin_y_nxt;
      active_r   <= !done;
    end
  end

  cor_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (accept && emit),
    .job              (job),
    .job_ready        (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_last_of_step (out_last_of_step),
    .out_circle_done  (out_circle_done)
  );

  `ASSERT_IMPL(a_done_on_last, clk, rst_n, out_valid && out_circle_done, out_last_of_step)
  `ASSERT_NEXT(a_idle_step_holds, clk, rst_n, accept && in_mode == MODE_STEP && !active_r, $stable(offset_x_r) && $stable(offset_y_r) && $stable(err_r) && !active_r)
  `ASSERT_NEXT(a_zero_radius_ends, clk, rst_n, accept && in_mode == MODE_START && in_radius == '0, !active_r)

endmodule
